// ----- sv/dbgm_pkg.sv -----
// Shared types and constants for the draw batch group merge core.
// Used by dbgm_front, dbgm_back and draw_batch_group_merge_core.
`timescale 1ns / 1ps

package dbgm_pkg;

    // Default sizes
    localparam int MAX_COMMANDS_DEF = 1024;
    localparam int KEY_GROUPS_DEF   = 512;
    localparam int JOB_QDEPTH       = 4;

    // Command codes
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_PUSH  = 2'd1;
    localparam logic [1:0] CMD_PULL  = 2'd2;

    // Input word
    typedef struct packed {
        logic [1:0]         cmd;
        logic               include_req;
        logic               blended;
        logic [7:0]         alpha_threshold;
        logic               two_sided;
        logic signed [31:0] vertex_offset;
        logic [31:0]        first_index;
        logic [31:0]        index_count;
    } t_in;

    // Result word
    typedef struct packed {
        logic               valid_res;
        logic [7:0]         out_alpha_threshold;
        logic               out_two_sided;
        logic [31:0]        out_index_count;
        logic [31:0]        out_first_index;
        logic signed [31:0] out_vertex_offset;
        logic [9:0]         position;
        logic               group_end;
        logic               list_end;
        logic [31:0]        merged_total;
        logic               overflow;
    } t_out;

    // Classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_PUSH,
        OP_PULL
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [8:0]  key;
        logic [8:0]  grp;
        logic [31:0] vo;
        logic [31:0] fi;
        logic [31:0] ic;
    } t_job;

    // One command store entry
    typedef struct packed {
        logic [8:0]  key;
        logic [31:0] vo;
        logic [31:0] fi;
        logic [31:0] ic;
    } t_sdata;

    // Back end states
    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_P_GRD,
        ST_P_SRD,
        ST_P_EXE,
        ST_Q_GRD,
        ST_Q_GCHK,
        ST_Q_WRD,
        ST_Q_WCHK,
        ST_Q_DRD,
        ST_Q_DOUT,
        ST_EMIT
    } t_bstate;

endpackage

// ----- sv/dbgm_front.sv -----
// Front end: accepts input words, filters and classifies them, queues jobs.
// Depends on dbgm_pkg.
`timescale 1ns / 1ps

module dbgm_front #(
    parameter int KEY_GROUPS = dbgm_pkg::KEY_GROUPS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  dbgm_pkg::t_in  i_in,
    input  logic           i_busy,
    output logic           o_job_valid,
    output dbgm_pkg::t_job o_job,
    input  logic           i_job_ready
);

    localparam int QD = dbgm_pkg::JOB_QDEPTH;
    localparam int PW = $clog2(QD);
    localparam int NW = $clog2(QD + 1);

    dbgm_pkg::t_job r_q [QD];
    logic [PW-1:0]  r_wp, r_rp;
    logic [NW-1:0]  r_cnt;

    logic           w_acc, w_keep, w_deq;
    dbgm_pkg::t_job w_job;
    logic [8:0]     w_key, w_rem;
    logic [17:0]    w_div;

    assign full  = (r_cnt == NW'(QD)) || i_busy;
    assign w_acc = push && !full;

    // classify and reduce the key to a group by shifted subtraction
    always_comb begin
        w_key  = {i_in.two_sided, i_in.alpha_threshold};
        w_rem  = w_key;
        w_div  = '0;
        for (int j = 8; j >= 0; j--) begin
            w_div = 18'(KEY_GROUPS) << j;
            if ({9'b0, w_rem} >= w_div) w_rem = w_rem - w_div[8:0];
        end
        w_job.key = w_key;
        w_job.grp = w_rem;
        w_job.vo  = i_in.vertex_offset;
        w_job.fi  = i_in.first_index;
        w_job.ic  = i_in.index_count;
        w_job.op  = dbgm_pkg::OP_CLEAR;
        w_keep    = 1'b0;
        unique case (i_in.cmd)
            dbgm_pkg::CMD_CLEAR: begin
                w_job.op = dbgm_pkg::OP_CLEAR;
                w_keep   = 1'b1;
            end
            dbgm_pkg::CMD_PUSH: begin
                w_job.op = dbgm_pkg::OP_PUSH;
                w_keep   = i_in.include_req && !i_in.blended;
            end
            dbgm_pkg::CMD_PULL: begin
                w_job.op = dbgm_pkg::OP_PULL;
                w_keep   = 1'b1;
            end
            default: w_keep = 1'b0;
        endcase
    end

    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_q[r_rp];
    assign w_deq       = o_job_valid && i_job_ready;

    // job queue storage
    always_ff @(posedge i_clk) begin
        if (w_acc && w_keep) r_q[r_wp] <= w_job;
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_acc && w_keep) r_wp <= r_wp + 1'b1;
            if (w_deq) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + NW'(w_acc && w_keep) - NW'(w_deq);
        end
    end

endmodule

// ----- sv/dbgm_back.sv -----
// Back end: runs clear, push and pull jobs on the group table and command store.
// Depends on dbgm_pkg.
`timescale 1ns / 1ps

module dbgm_back #(
    parameter int MAX_COMMANDS = dbgm_pkg::MAX_COMMANDS_DEF,
    parameter int KEY_GROUPS   = dbgm_pkg::KEY_GROUPS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  dbgm_pkg::t_job i_job,
    output logic           o_job_ready,
    output logic           o_busy,
    output logic           empty,
    input  logic           pop,
    output dbgm_pkg::t_out o_out
);

    localparam int SW = $clog2(MAX_COMMANDS);
    localparam int CW = $clog2(MAX_COMMANDS + 1);
    localparam int GW = $clog2(KEY_GROUPS);

    typedef struct packed {
        logic          valid;
        logic [SW-1:0] latest;
        logic [SW-1:0] head;
        logic [CW-1:0] size;
    } t_gent;

    // memories
    t_gent            grp_mem [KEY_GROUPS];
    dbgm_pkg::t_sdata st_data [MAX_COMMANDS];
    logic [SW-1:0]    st_next [MAX_COMMANDS];

    logic             grp_we;
    logic [GW-1:0]    grp_wa, grp_ra;
    t_gent            grp_wd, r_grp_rd;
    logic             sd_we, sn_we;
    logic [SW-1:0]    sd_wa, sn_wa, sn_wd, st_ra, r_sn_rd;
    dbgm_pkg::t_sdata sd_wd, r_sd_rd;

    always_ff @(posedge i_clk) begin
        if (grp_we) grp_mem[grp_wa] <= grp_wd;
        r_grp_rd <= grp_mem[grp_ra];
    end

    always_ff @(posedge i_clk) begin
        if (sd_we) st_data[sd_wa] <= sd_wd;
        if (sn_we) st_next[sn_wa] <= sn_wd;
        r_sd_rd <= st_data[st_ra];
        r_sn_rd <= st_next[st_ra];
    end

    // control registers
    dbgm_pkg::t_bstate r_state, n_state;
    logic              r_init, n_init;
    logic [GW:0]       r_g, n_g;
    logic [CW-1:0]     r_stored, n_stored, r_cursor, n_cursor;
    logic [CW-1:0]     r_start, n_start, r_k, n_k;
    logic [31:0]       r_merge, n_merge;
    logic              r_ovf, n_ovf, r_gend, n_gend;
    logic [SW-1:0]     r_slot, n_slot;
    dbgm_pkg::t_job    r_job, n_job;
    t_gent             r_ge, n_ge;
    dbgm_pkg::t_out    r_res, n_res, r_out, n_out;
    logic              r_out_v, n_out_v;

    logic              w_merge;
    logic [CW:0]       w_sum;
    logic [SW-1:0]     w_new;
    logic [CW-1:0]     w_off;

    assign o_busy = r_init;
    assign empty  = !r_out_v;
    assign o_out  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dbgm_pkg::ST_CLR;
            r_init   <= 1'b1;
            r_g      <= '0;
            r_stored <= '0;
            r_cursor <= '0;
            r_merge  <= '0;
            r_ovf    <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_init   <= n_init;
            r_g      <= n_g;
            r_stored <= n_stored;
            r_cursor <= n_cursor;
            r_merge  <= n_merge;
            r_ovf    <= n_ovf;
            r_out_v  <= n_out_v;
        end
    end

    // payload and scan registers
    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_k     <= n_k;
        r_gend  <= n_gend;
        r_slot  <= n_slot;
        r_job   <= n_job;
        r_ge    <= n_ge;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_init   = r_init;
        n_g      = r_g;
        n_stored = r_stored;
        n_cursor = r_cursor;
        n_start  = r_start;
        n_k      = r_k;
        n_merge  = r_merge;
        n_ovf    = r_ovf;
        n_gend   = r_gend;
        n_slot   = r_slot;
        n_job    = r_job;
        n_ge     = r_ge;
        n_res    = r_res;
        n_out    = r_out;
        n_out_v  = r_out_v && !pop;
        o_job_ready = 1'b0;
        grp_we = 1'b0;
        grp_wa = r_g[GW-1:0];
        grp_wd = '0;
        grp_ra = r_g[GW-1:0];
        sd_we  = 1'b0;
        sd_wa  = r_slot;
        sd_wd  = r_sd_rd;
        sn_we  = 1'b0;
        sn_wa  = r_ge.latest;
        sn_wd  = r_slot;
        st_ra  = r_slot;
        w_merge = r_ge.valid && (r_sd_rd.vo == r_job.vo) &&
                  (r_sd_rd.fi + r_sd_rd.ic == r_job.fi);
        w_sum   = {1'b0, r_start} + {1'b0, r_grp_rd.size};
        w_new   = r_stored[SW-1:0];
        w_off   = r_cursor - r_start;

        unique case (r_state)
            // clearing pass over the group table
            dbgm_pkg::ST_CLR: begin
                grp_we = 1'b1;
                n_g    = r_g + 1'b1;
                if (r_g == (GW+1)'(KEY_GROUPS - 1)) begin
                    n_init  = 1'b0;
                    n_state = dbgm_pkg::ST_IDLE;
                end
            end
            dbgm_pkg::ST_IDLE: begin
                o_job_ready = i_job_valid;
                n_job       = i_job;
                if (i_job_valid) begin
                    unique case (i_job.op)
                        dbgm_pkg::OP_CLEAR: begin
                            n_g      = '0;
                            n_stored = '0;
                            n_cursor = '0;
                            n_merge  = '0;
                            n_ovf    = 1'b0;
                            n_state  = dbgm_pkg::ST_CLR;
                        end
                        dbgm_pkg::OP_PUSH: n_state = dbgm_pkg::ST_P_GRD;
                        dbgm_pkg::OP_PULL: begin
                            n_g     = '0;
                            n_start = '0;
                            if (r_cursor >= r_stored) begin
                                n_res              = '0;
                                n_res.merged_total = r_merge;
                                n_res.overflow     = r_ovf;
                                n_state            = dbgm_pkg::ST_EMIT;
                            end else begin
                                n_state = dbgm_pkg::ST_Q_GRD;
                            end
                        end
                        default: n_state = dbgm_pkg::ST_IDLE;
                    endcase
                end
            end
            // push: read group, read its latest command, then merge, append or flag overflow
            dbgm_pkg::ST_P_GRD: begin
                grp_ra  = r_job.grp[GW-1:0];
                n_state = dbgm_pkg::ST_P_SRD;
            end
            dbgm_pkg::ST_P_SRD: begin
                n_ge    = r_grp_rd;
                st_ra   = r_grp_rd.latest;
                n_state = dbgm_pkg::ST_P_EXE;
            end
            dbgm_pkg::ST_P_EXE: begin
                n_state = dbgm_pkg::ST_IDLE;
                if (w_merge) begin
                    sd_we    = 1'b1;
                    sd_wa    = r_ge.latest;
                    sd_wd.ic = r_sd_rd.ic + r_job.ic;
                    n_merge  = r_merge + 1'b1;
                end else if (r_stored >= CW'(MAX_COMMANDS)) begin
                    n_ovf = 1'b1;
                end else begin
                    sd_we     = 1'b1;
                    sd_wa     = w_new;
                    sd_wd.key = r_job.key;
                    sd_wd.vo  = r_job.vo;
                    sd_wd.fi  = r_job.fi;
                    sd_wd.ic  = r_job.ic;
                    sn_we     = r_ge.valid;
                    sn_wd     = w_new;
                    grp_we        = 1'b1;
                    grp_wa        = r_job.grp[GW-1:0];
                    grp_wd.valid  = 1'b1;
                    grp_wd.latest = w_new;
                    grp_wd.head   = r_ge.valid ? r_ge.head : w_new;
                    grp_wd.size   = r_ge.size + 1'b1;
                    n_stored      = r_stored + 1'b1;
                end
            end
            // pull: find the group holding the cursor position
            dbgm_pkg::ST_Q_GRD: n_state = dbgm_pkg::ST_Q_GCHK;
            dbgm_pkg::ST_Q_GCHK: begin
                if ({1'b0, r_cursor} < w_sum) begin
                    n_slot  = r_grp_rd.head;
                    n_k     = w_off;
                    n_gend  = (w_off + 1'b1 == r_grp_rd.size);
                    n_state = (w_off == '0) ? dbgm_pkg::ST_Q_DRD : dbgm_pkg::ST_Q_WRD;
                end else if (r_g == (GW+1)'(KEY_GROUPS - 1)) begin
                    n_res              = '0;
                    n_res.merged_total = r_merge;
                    n_res.overflow     = r_ovf;
                    n_state            = dbgm_pkg::ST_EMIT;
                end else begin
                    n_start = w_sum[CW-1:0];
                    n_g     = r_g + 1'b1;
                    n_state = dbgm_pkg::ST_Q_GRD;
                end
            end
            // walk the group's chain one link at a time (ST_Q_WRD, then ST_Q_WCHK)
            dbgm_pkg::ST_Q_WRD: n_state = dbgm_pkg::ST_Q_WCHK;
            dbgm_pkg::ST_Q_WCHK: begin
                n_slot  = r_sn_rd;
                n_k     = r_k - 1'b1;
                n_state = (r_k == CW'(1)) ? dbgm_pkg::ST_Q_DRD : dbgm_pkg::ST_Q_WRD;
            end
            dbgm_pkg::ST_Q_DRD: n_state = dbgm_pkg::ST_Q_DOUT;
            dbgm_pkg::ST_Q_DOUT: begin
                n_res.valid_res           = 1'b1;
                n_res.out_alpha_threshold = r_sd_rd.key[7:0];
                n_res.out_two_sided       = r_sd_rd.key[8];
                n_res.out_index_count     = r_sd_rd.ic;
                n_res.out_first_index     = r_sd_rd.fi;
                n_res.out_vertex_offset   = r_sd_rd.vo;
                n_res.position            = 10'(r_cursor);
                n_res.group_end           = r_gend;
                n_res.list_end            = (r_cursor + 1'b1 == r_stored);
                n_res.merged_total        = r_merge;
                n_res.overflow            = r_ovf;
                n_cursor                  = r_cursor + 1'b1;
                n_state                   = dbgm_pkg::ST_EMIT;
            end
            // hand the result to the output register
            dbgm_pkg::ST_EMIT: begin
                if (!r_out_v || pop) begin
                    n_out   = r_res;
                    n_out_v = 1'b1;
                    n_state = dbgm_pkg::ST_IDLE;
                end
            end
            default: n_state = dbgm_pkg::ST_IDLE;
        endcase
    end

    // checks
    a_stored_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stored <= CW'(MAX_COMMANDS)) else $error("store count past capacity");
    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= r_stored) else $error("pull cursor past store count");
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dbgm_pkg::ST_EMIT && r_out_v && !pop) |=>
        (r_state == dbgm_pkg::ST_EMIT)) else $error("result overwrote waiting word");
    a_init_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !o_job_ready) else $error("job taken during clearing pass");

endmodule

// ----- sv/draw_batch_group_merge_core.sv -----
// Push: the back end takes the job, reads the group, reads the store, updates.
// Pull: group reads up to the cursor's group, chain walk, read; none left: emit.
// Clear: a pass over the group table; later words queue meanwhile.
// Reset (synchronous, active low) starts the clearing pass; full stays high
// until it ends. A 4-deep job queue decouples input from the engine.
`timescale 1ns / 1ps

module draw_batch_group_merge_core #(
    parameter int MAX_COMMANDS = dbgm_pkg::MAX_COMMANDS_DEF,
    parameter int KEY_GROUPS   = dbgm_pkg::KEY_GROUPS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  dbgm_pkg::t_in  i_in,
    output logic           empty,
    input  logic           pop,
    output dbgm_pkg::t_out o_out
);

    logic           w_job_valid, w_job_ready, w_busy;
    dbgm_pkg::t_job w_job;

    dbgm_front #(
        .KEY_GROUPS (KEY_GROUPS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .i_busy      (w_busy),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_ready (w_job_ready)
    );

    dbgm_back #(
        .MAX_COMMANDS (MAX_COMMANDS),
        .KEY_GROUPS   (KEY_GROUPS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_job_ready (w_job_ready),
        .o_busy      (w_busy),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out)
    );

endmodule

// ----- dv/tb_top.sv -----
// Testbench for draw_batch_group_merge_core: a cycle-free predictor of the draw
// grouper, random and directed push/clear/pull words, randomized push/pop idling.
// Depends on dbgm_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int STORE_DEPTH = 1024;
    localparam int GROUPS      = 512;
    localparam int WDOG_LIMIT  = 20000;
    // code with no operation behind it
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           push    = 1'b0;
    logic           pop     = 1'b0;
    dbgm_pkg::t_in  i_in    = '0;
    logic           full;
    logic           empty;
    dbgm_pkg::t_out o_out;

    draw_batch_group_merge_core i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .push   (push),
        .full   (full),
        .i_in   (i_in),
        .empty  (empty),
        .pop    (pop),
        .o_out  (o_out)
    );

    // Predicts the pull results of the grouper and holds them until popped
    class batch_scoreboard;
        logic [31:0]    cmd_count[STORE_DEPTH];
        logic [31:0]    cmd_first[STORE_DEPTH];
        logic [31:0]    cmd_voff[STORE_DEPTH];
        logic [8:0]     cmd_key[STORE_DEPTH];
        int unsigned    grp_latest[GROUPS];
        bit             grp_has_latest[GROUPS];
        int unsigned    grp_size[GROUPS];
        int unsigned    n_cmds;
        int unsigned    cursor;
        logic [31:0]    merges;
        bit             dropped;
        dbgm_pkg::t_out pending_q[$];
        int             errors;

        function new();
            errors = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (grp_has_latest[g]) begin
                grp_has_latest[g] = 1'b0;
                grp_size[g]       = 0;
                grp_latest[g]     = 0;
            end
            n_cmds  = 0;
            cursor  = 0;
            merges  = '0;
            dropped = 1'b0;
        endfunction

        function void add_draw(dbgm_pkg::t_in w);
            logic [8:0]  key;
            int unsigned slot;
            key = {w.two_sided, w.alpha_threshold};
            if (!w.include_req || w.blended)
                return;
            if (grp_has_latest[key]) begin
                slot = grp_latest[key];
                if (cmd_voff[slot] == w.vertex_offset &&
                    cmd_first[slot] + cmd_count[slot] == w.first_index) begin
                    cmd_count[slot] = cmd_count[slot] + w.index_count;
                    merges = merges + 32'd1;
                    return;
                end
            end
            if (n_cmds >= STORE_DEPTH) begin
                dropped = 1'b1;
                return;
            end
            slot            = n_cmds;
            cmd_count[slot] = w.index_count;
            cmd_first[slot] = w.first_index;
            cmd_voff[slot]  = w.vertex_offset;
            cmd_key[slot]   = key;
            grp_latest[key] = slot;
            grp_has_latest[key] = 1'b1;
            grp_size[key]++;
            n_cmds++;
        endfunction

        // Next command in key order, insertion order within a key
        function dbgm_pkg::t_out next_command();
            dbgm_pkg::t_out r;
            int unsigned    p, base, g, k;
            bit             found;
            r              = '0;
            r.merged_total = merges;
            r.overflow     = dropped;
            p              = cursor;
            base           = 0;
            found          = 1'b0;
            if (p >= n_cmds)
                return r;
            for (g = 0; g < GROUPS; g++) begin
                if (p < base + grp_size[g]) begin
                    found = 1'b1;
                    break;
                end
                base += grp_size[g];
            end
            if (!found)
                return r;
            k = 0;
            for (int s = 0; s < n_cmds; s++) begin
                if (cmd_key[s] != g)
                    continue;
                if (k == p - base) begin
                    r.valid_res           = 1'b1;
                    r.out_alpha_threshold = cmd_key[s][7:0];
                    r.out_two_sided       = cmd_key[s][8];
                    r.out_index_count     = cmd_count[s];
                    r.out_first_index     = cmd_first[s];
                    r.out_vertex_offset   = cmd_voff[s];
                    r.position            = p[9:0];
                    r.group_end           = (p - base + 1 == grp_size[g]);
                    r.list_end            = (p + 1 == n_cmds);
                    cursor                = p + 1;
                    return r;
                end
                k++;
            end
            return r;
        endfunction

        function void note_input(dbgm_pkg::t_in w);
            case (w.cmd)
                dbgm_pkg::CMD_CLEAR: wipe();
                dbgm_pkg::CMD_PUSH:  add_draw(w);
                dbgm_pkg::CMD_PULL:  pending_q.insert(pending_q.size(), next_command());
                default: ;
            endcase
        endfunction

        function void check_result(dbgm_pkg::t_out got);
            dbgm_pkg::t_out want;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (got.valid_res !== want.valid_res ||
                got.out_alpha_threshold !== want.out_alpha_threshold ||
                got.out_two_sided !== want.out_two_sided ||
                got.out_index_count !== want.out_index_count ||
                got.out_first_index !== want.out_first_index ||
                got.out_vertex_offset !== want.out_vertex_offset ||
                got.position !== want.position ||
                got.group_end !== want.group_end ||
                got.list_end !== want.list_end ||
                got.merged_total !== want.merged_total ||
                got.overflow !== want.overflow) begin
                $display("%0t: mismatch expected %p", $time, want);
                $display("%0t:          actual   %p", $time, got);
                errors++;
            end
        endfunction
    endclass

    batch_scoreboard sb = new();

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit rx_hold_req  = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Word builders
    function automatic dbgm_pkg::t_in draw_word(bit inc, bit bl, logic [7:0] alpha, bit ts,
                                                logic [31:0] vo, logic [31:0] fi,
                                                logic [31:0] ic);
        dbgm_pkg::t_in w;
        w                 = '0;
        w.cmd             = dbgm_pkg::CMD_PUSH;
        w.include_req     = inc;
        w.blended         = bl;
        w.alpha_threshold = alpha;
        w.two_sided       = ts;
        w.vertex_offset   = vo;
        w.first_index     = fi;
        w.index_count     = ic;
        return w;
    endfunction

    function automatic dbgm_pkg::t_in op_word(logic [1:0] c);
        dbgm_pkg::t_in w;
        w     = dbgm_pkg::t_in'({$urandom, $urandom, $urandom, $urandom});
        w.cmd = c;
        return w;
    endfunction

    // Drive one word and wait for the handshake
    task automatic send(dbgm_pkg::t_in w);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_in <= w;
        do @(posedge i_clk); while (full);
        sb.note_input(w);
    endtask

    // Wait until every predicted result has been popped
    task automatic drain();
        while (sb.pending_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Result side: random stalls plus one long hold-off on request
    initial begin
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                pop <= 1'b0;
                repeat (2500) @(posedge i_clk);
            end else begin
                pop <= !(rx_stall_pct > 0 && $urandom_range(99) < rx_stall_pct);
                @(posedge i_clk);
                if (pop && !empty)
                    sb.check_result(o_out);
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else if (++quiet >= WDOG_LIMIT) begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    // Random sequence: optional clear, pushes with chained runs, then pulls
    task automatic random_batch(ref int sent);
        logic [8:0]    keys[4];
        logic [8:0]    key;
        logic [31:0]   vo, fi, ic, last_end;
        int            n;
        dbgm_pkg::t_in w;
        foreach (keys[i]) keys[i] = 9'($urandom);
        keys[0] = ($urandom_range(1)) ? 9'h000 : 9'h1ff;
        vo       = '0;
        last_end = '0;
        key      = keys[0];
        n        = $urandom_range(1, 10);
        if ($urandom_range(3) != 0) begin
            send(op_word(dbgm_pkg::CMD_CLEAR));
            sent++;
        end
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) begin
                // noise: unused code, unselected or blended draw
                case ($urandom_range(2))
                    0: w = op_word(CMD_UNUSED);
                    1: w = draw_word(1'b0, 1'($urandom), 8'($urandom), 1'($urandom),
                                     $urandom, $urandom, $urandom);
                    default: w = draw_word(1'b1, 1'b1, 8'($urandom), 1'($urandom),
                                           $urandom, $urandom, $urandom);
                endcase
                send(w);
                sent++;
            end
            if ($urandom_range(9) >= 4 && i > 0) begin
                fi = last_end;
            end else begin
                key = keys[$urandom_range(3)];
                case ($urandom_range(3))
                    0: vo = '0;
                    1: vo = 32'hffff_ffff;
                    2: vo = 32'd5;
                    default: vo = $urandom;
                endcase
                fi = ($urandom_range(3) == 0) ? 32'hffff_fff0 : $urandom;
            end
            ic = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 40);
            last_end = fi + ic;
            send(draw_word(1, 0, key[7:0], key[8], vo, fi, ic));
            sent++;
        end
        repeat (n + $urandom_range(0, 2)) begin
            send(op_word(dbgm_pkg::CMD_PULL));
            sent++;
        end
    endtask

    initial begin
        int sent;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, merges with wrap, skipped draws, empty pulls
        send(op_word(dbgm_pkg::CMD_PULL));
        send(draw_word(1, 0, 8'hff, 1, 32'h8000_0000, 32'hffff_fffe, 32'h3));
        send(draw_word(1, 0, 8'hff, 1, 32'h8000_0000, 32'h1, 32'hffff_ffff));
        send(draw_word(1, 0, 8'h00, 0, 32'h7fff_ffff, 32'h0, 32'h0));
        send(draw_word(1, 0, 8'h00, 0, 32'h7fff_ffff, 32'h0, 32'h10));
        send(draw_word(1, 0, 8'h00, 0, 32'h0, 32'h10, 32'h1));
        send(draw_word(0, 0, 8'h00, 0, 32'h7fff_ffff, 32'h10, 32'h1));
        send(draw_word(1, 1, 8'h00, 0, 32'h0, 32'h11, 32'h1));
        send(op_word(CMD_UNUSED));
        send(draw_word(1, 0, 8'h80, 0, 32'h1, 32'h100, 32'h4));
        send(op_word(dbgm_pkg::CMD_PULL));
        send(op_word(dbgm_pkg::CMD_PULL));
        send(draw_word(1, 0, 8'h01, 0, 32'h2, 32'h200, 32'h4));
        repeat (5) send(op_word(dbgm_pkg::CMD_PULL));
        send(op_word(dbgm_pkg::CMD_CLEAR));
        send(op_word(dbgm_pkg::CMD_PULL));

        // Random part over four idling phases
        sent = 0;
        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct  = (ph == 1) ? 73 : (ph == 3) ? 36 : 0;
            rx_stall_pct = (ph == 2) ? 73 : (ph == 3) ? 36 : 0;
            while (sent < 100 * (ph + 1))
                random_batch(sent);
        end
        tx_idle_pct  = 0;
        rx_stall_pct = 0;

        // Back-pressure: result side holds off while pulls keep coming
        send(op_word(dbgm_pkg::CMD_CLEAR));
        for (int i = 0; i < 6; i++)
            send(draw_word(1, 0, 8'(i), 0, i, 32'h0, 32'h8));
        rx_hold_req = 1'b1;
        repeat (20) send(op_word(dbgm_pkg::CMD_PULL));
        push <= 1'b0;
        drain();

        // Fill the store past capacity, then merge into a full store
        send(op_word(dbgm_pkg::CMD_CLEAR));
        for (int i = 0; i < STORE_DEPTH + 6; i++)
            send(draw_word(1, 0, 8'(i % 4), 0, i, 32'h0, 32'h2));
        send(draw_word(1, 0, 8'd3, 0, STORE_DEPTH - 1, 32'h2, 32'h5));
        send(draw_word(1, 0, 8'd9, 1, 32'h0, 32'h0, 32'h1));
        repeat (3) send(op_word(dbgm_pkg::CMD_PULL));
        send(op_word(dbgm_pkg::CMD_CLEAR));
        send(op_word(dbgm_pkg::CMD_PULL));
        push <= 1'b0;

        drain();
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ----- files.f -----
sv/dbgm_pkg.sv
sv/dbgm_front.sv
sv/dbgm_back.sv
sv/draw_batch_group_merge_core.sv
dv/tb_top.sv
